// File: rtl/pps_pkg.sv
`default_nettype none
package pps_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int PRIO_W        = 8;
  localparam int TIME_W        = 16;
  localparam int IDX_W         = 4;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } pps_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_en;  // write one table entry this cycle
    logic launch;   // capture readiness keys into the tree leaves
    logic update;   // tree result is final: retire the slot
  } pps_cmd_t;

endpackage
`default_nettype wire

// File: rtl/pps_ctrl.sv
`default_nettype none
module pps_ctrl
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_operation,
  output logic          busy,
  output pps_cmd_t      cmd
);

  localparam int LVLS  = $clog2(MAX_TASKS);
  localparam int NREG  = (LVLS + 1) / 2;     // registered tree stages
  localparam int CNT_W = $clog2(NREG + 1);

  pps_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign cmd.load_en = accept && (in_operation == OP_LOAD);
  assign cmd.launch  = accept && (in_operation == OP_TICK);
  assign cmd.update  = (state_r == ST_UPD);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.launch) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = CNT_W'(NREG - 1);
        end
      end
      ST_SCAN: begin
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pps_min_tree.sv
`default_nettype none
module pps_min_tree
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int KEY_W     = PRIO_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [MAX_TASKS*KEY_W-1:0]    keys_in,
  output logic [KEY_W-1:0]                   best_key,
  output logic [$clog2(MAX_TASKS)-1:0]       best_idx
);

  localparam int LVLS = $clog2(MAX_TASKS);
  localparam int NLF  = 1 << LVLS;

  logic [KEY_W-1:0] key_q [LVLS+1][NLF];
  logic [LVLS-1:0]  idx_q [LVLS+1][NLF];

  // leaves: padding slots carry the worst key
  for (genvar i = 0; i < NLF; i++) begin : g_leaf
    always_ff @(posedge clk) begin
      if (load) begin
        if (i < MAX_TASKS) begin
          key_q[0][i] <= keys_in[i*KEY_W +: KEY_W];
        end else begin
          key_q[0][i] <= '1;
        end
        idx_q[0][i] <= LVLS'(i);
      end
    end
  end

  // pairwise minimum, lower index kept on ties; register every second level and the last
  for (genvar l = 1; l <= LVLS; l++) begin : g_lvl
    for (genvar i = 0; i < NLF; i++) begin : g_node
      if (i < (NLF >> l)) begin : g_used
        logic pick_hi;
        assign pick_hi = key_q[l-1][2*i+1] < key_q[l-1][2*i];
        if ((l % 2 == 0) || (l == LVLS)) begin : g_reg
          always_ff @(posedge clk) begin
            key_q[l][i] <= pick_hi ? key_q[l-1][2*i+1] : key_q[l-1][2*i];
            idx_q[l][i] <= pick_hi ? idx_q[l-1][2*i+1] : idx_q[l-1][2*i];
          end
        end else begin : g_comb
          always_comb begin
            key_q[l][i] = pick_hi ? key_q[l-1][2*i+1] : key_q[l-1][2*i];
            idx_q[l][i] = pick_hi ? idx_q[l-1][2*i+1] : idx_q[l-1][2*i];
          end
        end
      end else begin : g_unused
        always_comb begin
          key_q[l][i] = '0;
          idx_q[l][i] = '0;
        end
      end
    end
  end

  assign best_key = key_q[LVLS][0];
  assign best_idx = idx_q[LVLS][0];

endmodule
`default_nettype wire

// File: rtl/pps_datapath.sv
`default_nettype none
module pps_datapath
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pps_cmd_t            cmd,
  input  wire logic [IDX_W-1:0]    in_entry_index,
  input  wire logic [PRIO_W-1:0]   in_task_priority,
  input  wire logic [TIME_W-1:0]   in_arrival_time,
  input  wire logic [TIME_W-1:0]   in_burst_length,
  output logic                     out_valid,
  output logic                     out_idle,
  output logic [IDX_W-1:0]         out_running_index,
  output logic [TIME_W-1:0]        out_slot_end_time,
  output logic                     out_finished,
  output logic [TIME_W-1:0]        out_turnaround_time,
  output logic [TIME_W-1:0]        out_waiting_time
);

  localparam int IW    = $clog2(MAX_TASKS);
  localparam int KEY_W = PRIO_W + 1;

  logic                valid_r [MAX_TASKS];
  logic [PRIO_W-1:0]   prio_r  [MAX_TASKS];
  logic [TIME_W-1:0]   arr_r   [MAX_TASKS];
  logic [TIME_W-1:0]   burst_r [MAX_TASKS];
  logic [TIME_W-1:0]   rem_r   [MAX_TASKS];
  logic [TIME_W-1:0]   time_r, time_nxt;

  logic [MAX_TASKS*KEY_W-1:0] keys;
  logic [KEY_W-1:0]           best_key;
  logic [IW-1:0]              best_idx;

  logic                valid_q;
  logic                idle_q;
  logic [IDX_W-1:0]    run_q;
  logic [TIME_W-1:0]   end_q;
  logic                fin_q;
  logic [TIME_W-1:0]   tat_q;
  logic [TIME_W-1:0]   wait_q;

  // key = {not ready, priority}
  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_key
    logic rdy;
    assign rdy = valid_r[k] && (rem_r[k] != '0) && (arr_r[k] <= time_r);
    assign keys[k*KEY_W +: KEY_W] = {!rdy, prio_r[k]};
  end

  pps_min_tree #(
    .MAX_TASKS (MAX_TASKS),
    .KEY_W     (KEY_W)
  ) u_tree (
    .clk      (clk),
    .load     (cmd.launch),
    .keys_in  (keys),
    .best_key (best_key),
    .best_idx (best_idx)
  );

  // slot retire
  logic                no_task;
  logic [TIME_W-1:0]   w_rem, w_arr, w_burst;
  logic [TIME_W-1:0]   tat;
  logic                done;
  logic [IW+IDX_W-1:0] idx_ext;

  assign no_task  = best_key[KEY_W-1];
  assign w_rem    = rem_r[best_idx];
  assign w_arr    = arr_r[best_idx];
  assign w_burst  = burst_r[best_idx];
  assign time_nxt = (time_r == TIME_MAX) ? time_r : time_r + 1'b1;
  assign done     = !no_task && (w_rem == TIME_W'(1));
  assign tat      = time_nxt - w_arr;
  assign idx_ext  = {{IDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (cmd.update) begin
      time_r <= time_nxt;
    end
  end

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_ent
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (cmd.load_en && (int'(in_entry_index) == k)) begin
        valid_r[k] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load_en && (int'(in_entry_index) == k)) begin
        prio_r[k]  <= in_task_priority;
        arr_r[k]   <= in_arrival_time;
        burst_r[k] <= in_burst_length;
        rem_r[k]   <= in_burst_length;
      end else if (cmd.update && !no_task && (int'(best_idx) == k)) begin
        rem_r[k]   <= rem_r[k] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      idle_q <= no_task;
      run_q  <= no_task ? '0 : idx_ext[IDX_W-1:0];
      end_q  <= time_nxt;
      fin_q  <= done;
      tat_q  <= done ? tat : '0;
      wait_q <= (done && (tat >= w_burst)) ? tat - w_burst : '0;
    end
  end

  assign out_valid           = valid_q;
  assign out_idle            = idle_q;
  assign out_running_index   = run_q;
  assign out_slot_end_time   = end_q;
  assign out_finished        = fin_q;
  assign out_turnaround_time = tat_q;
  assign out_waiting_time    = wait_q;

endmodule
`default_nettype wire

// File: rtl/preemptive_priority_scheduler.sv
// Load word: written when taken, busy stays low, no result.
// Tick word: busy stays high through the scan and update states; the result strobe
//   rises once update ends and is taken at the next edge, where the next word can be
//   taken too; the scan length is set by the min-search tree depth.
// Results show for one cycle on out_valid; the receiver cannot stall.
// Sync active-low reset: time = 0, all entries invalid, controller idle.
`default_nettype none
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_operation,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [PRIO_W-1:0]  in_task_priority,
  input  wire logic [TIME_W-1:0]  in_arrival_time,
  input  wire logic [TIME_W-1:0]  in_burst_length,
  output logic                    out_valid,
  output logic                    out_idle,
  output logic [IDX_W-1:0]        out_running_index,
  output logic [TIME_W-1:0]       out_slot_end_time,
  output logic                    out_finished,
  output logic [TIME_W-1:0]       out_turnaround_time,
  output logic [TIME_W-1:0]       out_waiting_time
);

  // Flow of a tick word:
  //   accept   - readiness keys {not ready, priority} of all entries go into tree leaves
  //   scan     - pairwise min tree, up to two compare levels per register stage;
  //              ties keep the lower index, so the lowest index wins
  //   update   - winner's remaining time drops by one, time advances (saturating),
  //              turnaround / waiting computed on completion, result registered
  // Loads bypass the sequencer; a load to an index past the table is dropped.
  // Entries loaded with zero burst stay valid but never become ready.

  pps_cmd_t cmd;

  pps_ctrl #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .busy         (busy),
    .cmd          (cmd)
  );

  pps_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_entry_index      (in_entry_index),
    .in_task_priority    (in_task_priority),
    .in_arrival_time     (in_arrival_time),
    .in_burst_length     (in_burst_length),
    .out_valid           (out_valid),
    .out_idle            (out_idle),
    .out_running_index   (out_running_index),
    .out_slot_end_time   (out_slot_end_time),
    .out_finished        (out_finished),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time)
  );

endmodule
`default_nettype wire

// File: test/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 1ps

module preemptive_priority_scheduler_tb;
  import pps_pkg::*;

  // Watchdog: cycles in a row with no word taken and no slot report seen.
  // The slowest correct word is a full sender gap plus a tick,
  // so this leaves ample margin.
  localparam int STALL_LIMIT = 1000;

  // Cycles to keep watching once nothing is pending.
  localparam int DRAIN_CYCLES = 16;

  // Sender gap modes, switched in stretches during the random mix.
  localparam int GAP_NONE  = 0;
  localparam int GAP_SHORT = 1;
  localparam int GAP_FULL  = 2;

  // One expected slot report, field for field as the block shows it.
  typedef struct packed {
    logic              idle;
    logic [IDX_W-1:0]  running;
    logic [TIME_W-1:0] end_time;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } slot_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = OP_LOAD;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic [PRIO_W-1:0]  in_task_priority = '0;
  logic [TIME_W-1:0]  in_arrival_time = '0;
  logic [TIME_W-1:0]  in_burst_length = '0;
  logic               out_valid;
  logic               out_idle;
  logic [IDX_W-1:0]   out_running_index;
  logic [TIME_W-1:0]  out_slot_end_time;
  logic               out_finished;
  logic [TIME_W-1:0]  out_turnaround_time;
  logic [TIME_W-1:0]  out_waiting_time;

  // Scheduler shadow: task table and slot clock, updated when a word is taken.
  logic [TIME_W-1:0]  sched_time = '0;
  logic               slot_live   [MAX_TASKS_DEF] = '{default: 1'b0};
  logic [PRIO_W-1:0]  slot_prio   [MAX_TASKS_DEF] = '{default: '0};
  logic [TIME_W-1:0]  slot_arrive [MAX_TASKS_DEF] = '{default: '0};
  logic [TIME_W-1:0]  slot_burst  [MAX_TASKS_DEF] = '{default: '0};
  logic [TIME_W-1:0]  slot_left   [MAX_TASKS_DEF] = '{default: '0};

  // Slot reports predicted but not yet seen on the result port, oldest first.
  slot_report_t       pending_slots [$];
  slot_report_t       head_slot;

  int                 gap_mode = GAP_FULL;
  int                 mismatches = 0;
  int                 loads_sent = 0;
  int                 ticks_sent = 0;
  int                 tasks_done = 0;
  int                 idle_slots = 0;
  int                 stall_cycles = 0;

  always #1 clk = ~clk;

  preemptive_priority_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_entry_index      (in_entry_index),
    .in_task_priority    (in_task_priority),
    .in_arrival_time     (in_arrival_time),
    .in_burst_length     (in_burst_length),
    .out_valid           (out_valid),
    .out_idle            (out_idle),
    .out_running_index   (out_running_index),
    .out_slot_end_time   (out_slot_end_time),
    .out_finished        (out_finished),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time)
  );

  function automatic int draw_gap();
    case (gap_mode)
      GAP_NONE:  return 0;
      GAP_SHORT: return $urandom_range(0, 2);
      default:   return $urandom_range(0, 15);
    endcase
  endfunction

  // Arrival a little behind or ahead of the slot clock, so most tasks get to run.
  function automatic logic [TIME_W-1:0] near_arrival();
    int t;
    t = int'(sched_time) - 16 + $urandom_range(0, 24);
    if (t < 0) t = 0;
    if (t > int'(TIME_MAX)) t = int'(TIME_MAX);
    return t[TIME_W-1:0];
  endfunction

  // Apply one taken word to the shadow table. A tick picks the ready task with
  // the smallest priority value (lowest index on a tie), runs it for one slot
  // and queues the slot report.
  task automatic record_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [PRIO_W-1:0] prio,
                             input logic [TIME_W-1:0] arr,
                             input logic [TIME_W-1:0] burst);
    slot_report_t rpt;
    int winner;
    if (op == OP_LOAD) begin
      loads_sent++;
      if (int'(idx) < MAX_TASKS_DEF) begin
        slot_live[idx]   = 1'b1;
        slot_prio[idx]   = prio;
        slot_arrive[idx] = arr;
        slot_burst[idx]  = burst;
        slot_left[idx]   = burst;
      end
    end else begin
      ticks_sent++;
      winner = -1;
      for (int k = 0; k < MAX_TASKS_DEF; k++) begin
        if (slot_live[k] && slot_left[k] != '0 && slot_arrive[k] <= sched_time) begin
          if (winner < 0 || slot_prio[k] < slot_prio[winner]) winner = k;
        end
      end
      // clock saturates at its top value
      sched_time = (sched_time == TIME_MAX) ? TIME_MAX : sched_time + 1'b1;
      rpt = '0;
      rpt.end_time = sched_time;
      rpt.idle = (winner < 0);
      if (winner >= 0) begin
        rpt.running = winner[IDX_W-1:0];
        slot_left[winner] = slot_left[winner] - 1'b1;
        if (slot_left[winner] == '0) begin
          rpt.finished = 1'b1;
          rpt.turnaround = sched_time - slot_arrive[winner];
          // saturation can squeeze turnaround below the burst: floor at zero
          rpt.waiting = (rpt.turnaround >= slot_burst[winner]) ?
                        rpt.turnaround - slot_burst[winner] : '0;
          tasks_done++;
        end
      end else begin
        idle_slots++;
      end
      pending_slots.push_back(rpt);
    end
  endtask

  // Drive one word at the falling edge after a random gap and hold it until a
  // rising edge sees busy low. start stays high on return, so back-to-back
  // words keep it high without a dip.
  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [PRIO_W-1:0] prio,
                           input logic [TIME_W-1:0] arr,
                           input logic [TIME_W-1:0] burst);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start            <= 1'b1;
    in_operation     <= op;
    in_entry_index   <= idx;
    in_task_priority <= prio;
    in_arrival_time  <= arr;
    in_burst_length  <= burst;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    record_word(op, idx, prio, arr, burst);
  endtask

  task automatic send_load(input logic [IDX_W-1:0] idx, input logic [PRIO_W-1:0] prio,
                           input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] burst);
    send_word(OP_LOAD, idx, prio, arr, burst);
  endtask

  // Tick words carry junk in the unused fields; the block must ignore it.
  task automatic send_tick();
    send_word(OP_TICK, IDX_W'($urandom), PRIO_W'($urandom), TIME_W'($urandom),
              TIME_W'($urandom));
  endtask

  // One random word: mostly ticks, loads with short bursts near the clock and
  // bunched priorities for ties; now and then full-range fields.
  task automatic send_random_word();
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] burst;
    int pick;
    if ($urandom_range(0, 9) < 4) begin
      prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7)) : PRIO_W'($urandom);
      arr = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : near_arrival();
      pick = $urandom_range(0, 39);
      if (pick == 0) burst = TIME_W'($urandom);
      else if (pick < 4) burst = '0;
      else burst = TIME_W'($urandom_range(1, 8));
      send_load(IDX_W'($urandom), prio, arr, burst);
    end else begin
      send_tick();
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Hand-picked words: empty table, field extremes, ties, preemption, reload,
  // zero burst and future arrival.
  task automatic test_directed_cases();
    gap_mode = GAP_FULL;
    send_tick();                                 // nothing loaded: idle slot
    send_load(4'd0, 8'd255, 16'd0, 16'd1);
    send_tick();                                 // runs and finishes at once
    send_load(4'd15, 8'd0, 16'd0, 16'd0);        // zero burst: never ready
    send_load(4'd5, 8'd0, 16'd0, 16'd2);
    send_load(4'd3, 8'd0, 16'd0, 16'd2);         // tie with 5, lower index wins
    repeat (4) send_tick();
    send_load(4'd2, 8'd50, sched_time, 16'd3);
    send_tick();
    send_load(4'd1, 8'd20, sched_time, 16'd1);   // preempts the partly run task
    send_tick();
    send_tick();
    send_load(4'd2, 8'd50, sched_time, 16'd1);   // reload of a partly run task
    send_tick();
    send_load(4'd4, 8'd0, sched_time + 16'd2, 16'd1);  // arrives two slots out
    send_load(4'd9, 8'd128, 16'd0, 16'd3);
    repeat (3) send_tick();
    send_load(4'd6, 8'd255, TIME_MAX, TIME_MAX); // all-ones fields, far future
    repeat (2) send_tick();
  endtask

  // Random mix, sender idling switched in stretches of 50 words.
  task automatic test_random_mix();
    for (int n = 0; n < 1040; n++) begin
      if (n % 50 == 0) gap_mode = $urandom_range(GAP_NONE, GAP_FULL);
      send_random_word();
    end
  endtask

  // One task held at the top priority through a long back-to-back run, then
  // reloaded short and finally with zero burst.
  task automatic test_long_burst();
    gap_mode = GAP_NONE;
    // entry 0 at priority 0 wins every slot
    send_load(4'd0, 8'd0, sched_time, 16'd20);
    repeat (20) send_tick();
    gap_mode = GAP_FULL;
    send_load(4'd0, 8'd0, sched_time, 16'd1);
    send_tick();
    send_load(4'd0, 8'd0, sched_time, 16'd0);
    for (int k = 0; k < 60; k++) send_random_word();
  endtask

  // Result checker: each report is taken in the cycle it shows and matched
  // against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_slots.size() == 0) begin
        $display("%0t ns: slot report with none expected, expected nothing, got end time %0d",
                 $time, out_slot_end_time);
        mismatches++;
      end else begin
        head_slot = pending_slots.pop_front();
        check_field("idle", head_slot.idle, out_idle);
        check_field("running_index", head_slot.running, out_running_index);
        check_field("slot_end_time", head_slot.end_time, out_slot_end_time);
        check_field("finished", head_slot.finished, out_finished);
        check_field("turnaround_time", head_slot.turnaround, out_turnaround_time);
        check_field("waiting_time", head_slot.waiting, out_waiting_time);
      end
    end
  end

  // Watchdog: any word taken or report seen counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_mix();
    test_long_burst();

    @(negedge clk);
    start <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads and %0d ticks: %0d tasks completed, %0d idle slots,",
             loads_sent, ticks_sent, tasks_done, idle_slots);
    $display("with ties, preemption, reloads, zero bursts and back-to-back tick runs.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
